>>> src/btpe_pkg.sv
// Shared types, constants and helpers for the braided torus point evaluator.
// Depends on nothing; used by btpe_sincos and braided_torus_point_eval_top.
`default_nettype none

package btpe_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_AMP  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_RAD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TUBE_RAD  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAID_CNT = 8'd3;

  // Field widths fixed by the interface
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BRAID_W    = 4;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned TRIG_W     = 32;  // Q30 sine/cosine, range [-1, 1]
  localparam int unsigned CLIP_IN_W  = 40;

  // Sine/cosine pipeline depth
  localparam int unsigned SC_STAGES = 11;

  // Q30 constants
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Reciprocals for exact floor division of values below 2^30:
  // m = ceil(2^(30+l) / d), l = ceil(log2 d), shift = 30 + l
  localparam int unsigned K_DIV72 = 37;
  localparam int unsigned K_DIV56 = 36;
  localparam int unsigned K_DIV42 = 36;
  localparam int unsigned K_DIV30 = 35;
  localparam int unsigned K_DIV20 = 35;
  localparam int unsigned K_DIV12 = 34;
  localparam int unsigned K_DIV6  = 33;
  localparam logic [31:0] M_DIV72 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [31:0] M_DIV56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [31:0] M_DIV42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [31:0] M_DIV30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [31:0] M_DIV20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [31:0] M_DIV12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam logic [31:0] M_DIV6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);

  typedef struct packed {
    logic [OUT_W-1:0] val;
    logic             clip;
  } clip_res_t;

  // Floor division by a constant through its reciprocal
  function automatic logic [29:0] rcp_div(input logic [29:0] v, input logic [31:0] m,
                                          input int unsigned k);
    logic [61:0] p;
    p = 62'(v) * 62'(m);
    return 30'(p >> k);
  endfunction

  // Saturate to the signed output range
  function automatic clip_res_t clip_out(input logic signed [CLIP_IN_W-1:0] v);
    clip_res_t res;
    if (v > CLIP_IN_W'((1 << (OUT_W - 1)) - 1)) begin
      res.val  = {1'b0, {(OUT_W-1){1'b1}}};
      res.clip = 1'b1;
    end else if (v < -CLIP_IN_W'(1 << (OUT_W - 1))) begin
      res.val  = {1'b1, {(OUT_W-1){1'b0}}};
      res.clip = 1'b1;
    end else begin
      res.val  = v[OUT_W-1:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/braided_torus_point_eval_top.sv
// Braided torus point evaluator: point, u-partials and v-partials per (u, v).
// Depends on btpe_pkg and btpe_sincos.
//
//   port group | dir | handshake             | contents
//   in_*       | in  | in_valid / in_ready   | angle_u, angle_v
//   out_*      | out | out_valid / out_ready | pos, du, dv vectors, saturated
//   cfg_*      | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while out_ready is held high; out_valid rises once
// the item has passed 17 register stages: one angle stage, 11 sine/cosine stages, four
// product stages, output register.
// Each stage holds while the next is full and stalled, so bubbles close up and
// nothing is dropped or repeated. rst_n (synchronous) clears valid bits and
// loads the register defaults; the block is ready on the next cycle.
`default_nettype none

module braided_torus_point_eval_top #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ANGLE_BITS-1:0]             in_angle_u,
  input  wire logic [ANGLE_BITS-1:0]             in_angle_v,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_pos_x,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_pos_y,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_pos_z,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_du_x,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_du_y,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_du_z,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_dv_x,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_dv_y,
  output logic signed [btpe_pkg::OUT_W-1:0]      out_dv_z,
  output logic                                   out_saturated,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [btpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [btpe_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import btpe_pkg::*;

  localparam int NS     = SC_STAGES + 6;
  localparam int ST_SC  = 1;
  localparam int ST_P1  = SC_STAGES + 1;
  localparam int ST_P2  = SC_STAGES + 2;
  localparam int ST_P3  = SC_STAGES + 3;
  localparam int ST_P4  = SC_STAGES + 4;
  localparam int ST_OUT = SC_STAGES + 5;

  localparam int ARR_W = 33 - FRAC_BITS;  // rounded a*R
  localparam int ARN_W = ARR_W + 5;       // times N
  localparam int DVP_W = FRAC_BITS + 2;
  localparam int DV_W  = FRAC_BITS + 3;
  localparam int DVC_W = FRAC_BITS + 3;
  localparam int BASE_W = 25;
  localparam int PZ_W   = 20;
  localparam int DUZ_W  = 24;
  localparam int PXY_W  = 26;

  // Configuration registers
  logic signed [CFG_DATA_W-1:0] amp_r, maj_r, tube_r;
  logic [BRAID_W-1:0]           braid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= 16'sd4096;
      maj_r   <= 16'sd4096;
      tube_r  <= 16'sd4096;
      braid_r <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WAVE_AMP:  amp_r   <= cfg_data;
        CFG_MAJOR_RAD: maj_r   <= cfg_data;
        CFG_TUBE_RAD:  tube_r  <= cfg_data;
        CFG_BRAID_CNT: braid_r <= cfg_data[BRAID_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid chain and per-stage load enables
  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS:0]   ld;

  always_comb begin
    ld[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) ld[i] = !vld_r[i] || ld[i+1];
    vld_nxt = vld_r;
    for (int i = 0; i < NS; i++) begin
      if (ld[i]) vld_nxt[i] = (i == 0) ? in_valid : vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  assign in_ready  = ld[0];
  assign out_valid = vld_r[ST_OUT];

  // Angle stage: u, v and N*u modulo a turn
  logic [ANGLE_BITS-1:0] u_r, v_r, nu_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      u_r  <= in_angle_u;
      v_r  <= in_angle_v;
      nu_r <= ANGLE_BITS'(in_angle_u * braid_r);
    end
  end

  // Three sine/cosine pipelines in lockstep
  logic signed [TRIG_W-1:0] su, cu, sv, cv, snu, cnu;
  logic [SC_STAGES-1:0]     sc_en;

  assign sc_en = ld[ST_SC +: SC_STAGES];

  btpe_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_u (
    .clk(clk), .stage_en(sc_en), .angle(u_r), .sin_q(su), .cos_q(cu)
  );
  btpe_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_v (
    .clk(clk), .stage_en(sc_en), .angle(v_r), .sin_q(sv), .cos_q(cv)
  );
  btpe_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_nu (
    .clk(clk), .stage_en(sc_en), .angle(nu_r), .sin_q(snu), .cos_q(cnu)
  );

  // P1: scale trig values by the registers; form a*R, 5*a*N and the v-partial terms
  logic signed [47:0] acn_p, asn_p, rcv_p, rsv_p;
  logic signed [32:0] ar_p;
  logic signed [63:0] cusv_p, susv_p;
  logic signed [34:0] cv5_p;
  logic signed [4:0]  n_s;
  logic signed [16:0] acn_r, asn_r, rcv_r, rsv_r;
  logic signed [ARR_W-1:0] arr_r;
  logic signed [22:0] an5_r;
  logic signed [DVP_W-1:0] cusv_r, susv_r;
  logic signed [DVC_W-1:0] dvc_r;
  logic signed [TRIG_W-1:0] su1_r, cu1_r, snu1_r, cnu1_r;

  always_comb begin
    n_s    = $signed({1'b0, braid_r});
    acn_p  = 48'(amp_r) * 48'(cnu);
    asn_p  = 48'(amp_r) * 48'(snu);
    rcv_p  = 48'(tube_r) * 48'(cv);
    rsv_p  = 48'(tube_r) * 48'(sv);
    ar_p   = 33'(amp_r) * 33'(maj_r);
    cusv_p = 64'(cu) * 64'(sv);
    susv_p = 64'(su) * 64'(sv);
    cv5_p  = 35'(cv) * 35'sd5;
  end

  always_ff @(posedge clk) begin
    if (ld[ST_P1]) begin
      acn_r  <= 17'((acn_p + (48'sd1 <<< 29)) >>> 30);
      asn_r  <= 17'((asn_p + (48'sd1 <<< 29)) >>> 30);
      rcv_r  <= 17'((rcv_p + (48'sd1 <<< 29)) >>> 30);
      rsv_r  <= 17'((rsv_p + (48'sd1 <<< 29)) >>> 30);
      arr_r  <= ARR_W'((ar_p + (33'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      an5_r  <= 23'(amp_r) * 23'(n_s) * 23'sd5;
      cusv_r <= DVP_W'((cusv_p + (64'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS));
      susv_r <= DVP_W'((susv_p + (64'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS));
      dvc_r  <= DVC_W'((cv5_p + (35'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS));
      su1_r  <= su;
      cu1_r  <= cu;
      snu1_r <= snu;
      cnu1_r <= cnu;
    end
  end

  // P2: base radius, z, a*R*N, z-partials, v-partials with the sign of r
  logic signed [21:0] one_acn;
  logic signed [37:0] rb_p;
  logic signed [20:0] pz5;
  logic signed [54:0] duz_p;
  logic               r_neg;
  logic signed [BASE_W-1:0] base_r;
  logic signed [PZ_W-1:0]   pz2_r;
  logic signed [ARN_W-1:0]  arn_r;
  logic signed [DUZ_W-1:0]  duz2_r;
  logic signed [DV_W-1:0]   dvx2_r, dvy2_r, dvz2_r;
  logic signed [TRIG_W-1:0] su2_r, cu2_r, snu2_r;

  always_comb begin
    one_acn = (22'sd1 <<< FRAC_BITS) + 22'(acn_r);
    rb_p    = 38'(maj_r) * 38'(one_acn);
    pz5     = (21'(rsv_r) + 21'(asn_r)) * 21'sd5;
    duz_p   = 55'(an5_r) * 55'(cnu1_r);
    r_neg   = tube_r[CFG_DATA_W-1];
  end

  always_ff @(posedge clk) begin
    if (ld[ST_P2]) begin
      base_r <= BASE_W'(rcv_r) +
                BASE_W'((rb_p + (38'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      pz2_r  <= PZ_W'((pz5 + 21'sd1) >>> 1);
      arn_r  <= ARN_W'(arr_r) * ARN_W'(n_s);
      duz2_r <= DUZ_W'((duz_p + (55'sd1 <<< 30)) >>> 31);
      dvx2_r <= r_neg ? DV_W'(cusv_r) : -DV_W'(cusv_r);
      dvy2_r <= r_neg ? DV_W'(susv_r) : -DV_W'(susv_r);
      dvz2_r <= r_neg ? -DV_W'(dvc_r) : DV_W'(dvc_r);
      su2_r  <= su1_r;
      cu2_r  <= cu1_r;
      snu2_r <= snu1_r;
    end
  end

  // P3: point x, y and a*R*N*sin(Nu)
  logic signed [56:0] px_p, py_p;
  logic signed [ARN_W+TRIG_W-1:0] arns_p;
  logic signed [PXY_W-1:0] px3_r, py3_r;
  logic signed [ARN_W-1:0] arns_r;
  logic signed [PZ_W-1:0]  pz3_r;
  logic signed [DUZ_W-1:0] duz3_r;
  logic signed [DV_W-1:0]  dvx3_r, dvy3_r, dvz3_r;
  logic signed [TRIG_W-1:0] su3_r, cu3_r;

  always_comb begin
    px_p   = 57'(base_r) * 57'(cu2_r);
    py_p   = 57'(base_r) * 57'(su2_r);
    arns_p = (ARN_W + TRIG_W)'(arn_r) * (ARN_W + TRIG_W)'(snu2_r);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_P3]) begin
      px3_r  <= PXY_W'((px_p + (57'sd1 <<< 29)) >>> 30);
      py3_r  <= PXY_W'((py_p + (57'sd1 <<< 29)) >>> 30);
      arns_r <= ARN_W'((arns_p + ((ARN_W + TRIG_W)'(1) <<< 29)) >>> 30);
      pz3_r  <= pz2_r;
      duz3_r <= duz2_r;
      dvx3_r <= dvx2_r;
      dvy3_r <= dvy2_r;
      dvz3_r <= dvz2_r;
      su3_r  <= su2_r;
      cu3_r  <= cu2_r;
    end
  end

  // P4: braid terms of the u-partials
  logic signed [ARN_W+TRIG_W-1:0] m1_p, m2_p;
  logic signed [ARN_W-1:0] m1_r, m2_r;
  logic signed [PXY_W-1:0] px4_r, py4_r;
  logic signed [PZ_W-1:0]  pz4_r;
  logic signed [DUZ_W-1:0] duz4_r;
  logic signed [DV_W-1:0]  dvx4_r, dvy4_r, dvz4_r;

  always_comb begin
    m1_p = (ARN_W + TRIG_W)'(arns_r) * (ARN_W + TRIG_W)'(cu3_r);
    m2_p = (ARN_W + TRIG_W)'(arns_r) * (ARN_W + TRIG_W)'(su3_r);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_P4]) begin
      m1_r   <= ARN_W'((m1_p + ((ARN_W + TRIG_W)'(1) <<< 29)) >>> 30);
      m2_r   <= ARN_W'((m2_p + ((ARN_W + TRIG_W)'(1) <<< 29)) >>> 30);
      px4_r  <= px3_r;
      py4_r  <= py3_r;
      pz4_r  <= pz3_r;
      duz4_r <= duz3_r;
      dvx4_r <= dvx3_r;
      dvy4_r <= dvy3_r;
      dvz4_r <= dvz3_r;
    end
  end

  // Output stage: final u-partials and saturation
  logic signed [CLIP_IN_W-1:0] dux_w, duy_w;
  clip_res_t c_px, c_py, c_pz, c_dux, c_duy, c_duz, c_dvx, c_dvy, c_dvz;

  always_comb begin
    dux_w = -CLIP_IN_W'(py4_r) - CLIP_IN_W'(m1_r);
    duy_w = CLIP_IN_W'(px4_r) - CLIP_IN_W'(m2_r);
    c_px  = clip_out(CLIP_IN_W'(px4_r));
    c_py  = clip_out(CLIP_IN_W'(py4_r));
    c_pz  = clip_out(CLIP_IN_W'(pz4_r));
    c_dux = clip_out(dux_w);
    c_duy = clip_out(duy_w);
    c_duz = clip_out(CLIP_IN_W'(duz4_r));
    c_dvx = clip_out(CLIP_IN_W'(dvx4_r));
    c_dvy = clip_out(CLIP_IN_W'(dvy4_r));
    c_dvz = clip_out(CLIP_IN_W'(dvz4_r));
  end

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      out_pos_x     <= c_px.val;
      out_pos_y     <= c_py.val;
      out_pos_z     <= c_pz.val;
      out_du_x      <= c_dux.val;
      out_du_y      <= c_duy.val;
      out_du_z      <= c_duz.val;
      out_dv_x      <= c_dvx.val;
      out_dv_y      <= c_dvy.val;
      out_dv_z      <= c_dvz.val;
      out_saturated <= c_px.clip | c_py.clip | c_pz.clip | c_dux.clip | c_duy.clip |
                       c_duz.clip | c_dvx.clip | c_dvy.clip | c_dvz.clip;
    end
  end

endmodule

`default_nettype wire

>>> src/btpe_sincos.sv
// Pipelined fixed-point sine/cosine of a turn fraction (Taylor, Horner form).
// Depends on btpe_pkg; stage enables come from the owner's valid chain.
`default_nettype none

module btpe_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic [btpe_pkg::SC_STAGES-1:0]       stage_en,
  input  wire logic [ANGLE_BITS-1:0]                angle,
  output logic signed [btpe_pkg::TRIG_W-1:0]        sin_q,
  output logic signed [btpe_pkg::TRIG_W-1:0]        cos_q
);
  import btpe_pkg::*;

  localparam int unsigned TA_W = ANGLE_BITS - 2;
  localparam int unsigned PR_W = TA_W + 31;
  localparam logic [TA_W-1:0] OCT_HALF = TA_W'(1) << (ANGLE_BITS - 3);
  localparam logic [TA_W:0]   QUAD_FULL = (TA_W + 1)'(1) << TA_W;
  localparam logic [PR_W-1:0] X_RND = PR_W'(1) << (ANGLE_BITS - 3);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  // Carried control and operands
  logic [1:0]  quad_r [0:9];
  logic        swap_r [0:9];
  logic [29:0] x_r    [0:8];
  logic [29:0] xx_r   [1:6];

  logic [30:0] sa_r, ca_r, sb_r, cb_r, sc_r, cc_r, sd_r, cd_r, cf_r;
  logic [29:0] ps1_r, pc1_r, ps2_r, pc2_r, ps3_r, pc3_r, sf_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  // Octant fold and conversion to radians
  logic [TA_W-1:0] ta;
  logic            swap_nxt;
  logic [TA_W-1:0] tf;
  logic [PR_W-1:0] xp;
  logic [29:0]     x_nxt;

  always_comb begin
    ta       = angle[TA_W-1:0];
    swap_nxt = ta > OCT_HALF;
    tf       = swap_nxt ? TA_W'(QUAD_FULL - (TA_W + 1)'(ta)) : ta;
    xp       = PR_W'(tf) * PR_W'(HALF_PI_Q30);
    x_nxt    = 30'((xp + X_RND) >> TA_W);
  end

  // Horner steps: the square of x and the products by it and by x
  logic [59:0] xx_p;
  logic [60:0] ps1_p, pc1_p, ps2_p, pc2_p, ps3_p, pc3_p, sf_p;

  always_comb begin
    xx_p  = 60'(x_r[0]) * 60'(x_r[0]);
    ps1_p = 61'(xx_r[2]) * 61'(sa_r);
    pc1_p = 61'(xx_r[2]) * 61'(ca_r);
    ps2_p = 61'(xx_r[4]) * 61'(sb_r);
    pc2_p = 61'(xx_r[4]) * 61'(cb_r);
    ps3_p = 61'(xx_r[6]) * 61'(sc_r);
    pc3_p = 61'(xx_r[6]) * 61'(cc_r);
    sf_p  = 61'(x_r[8]) * 61'(sd_r);
  end

  // Quadrant mapping
  logic signed [TRIG_W-1:0] so, co, sin_nxt, cos_nxt;

  always_comb begin
    so = $signed({1'b0, swap_r[9] ? cf_r : {1'b0, sf_r}});
    co = $signed({1'b0, swap_r[9] ? {1'b0, sf_r} : cf_r});
    case (quad_r[9])
      QUAD_I:   begin sin_nxt = so;  cos_nxt = co;  end
      QUAD_II:  begin sin_nxt = co;  cos_nxt = -so; end
      QUAD_III: begin sin_nxt = -so; cos_nxt = -co; end
      default:  begin sin_nxt = -co; cos_nxt = so;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      quad_r[0] <= angle[ANGLE_BITS-1 -: 2];
      swap_r[0] <= swap_nxt;
      x_r[0]    <= x_nxt;
    end
    for (int k = 1; k < 10; k++) begin
      if (stage_en[k]) begin
        quad_r[k] <= quad_r[k-1];
        swap_r[k] <= swap_r[k-1];
      end
    end
    for (int k = 1; k < 9; k++) begin
      if (stage_en[k]) x_r[k] <= x_r[k-1];
    end
    if (stage_en[1]) xx_r[1] <= 30'(xx_p >> 30);
    for (int k = 2; k < 7; k++) begin
      if (stage_en[k]) xx_r[k] <= xx_r[k-1];
    end
    if (stage_en[2]) begin
      sa_r <= Q30_ONE - 31'(rcp_div(xx_r[1], M_DIV72, K_DIV72));
      ca_r <= Q30_ONE - 31'(rcp_div(xx_r[1], M_DIV56, K_DIV56));
    end
    if (stage_en[3]) begin
      ps1_r <= 30'(ps1_p >> 30);
      pc1_r <= 30'(pc1_p >> 30);
    end
    if (stage_en[4]) begin
      sb_r <= Q30_ONE - 31'(rcp_div(ps1_r, M_DIV42, K_DIV42));
      cb_r <= Q30_ONE - 31'(rcp_div(pc1_r, M_DIV30, K_DIV30));
    end
    if (stage_en[5]) begin
      ps2_r <= 30'(ps2_p >> 30);
      pc2_r <= 30'(pc2_p >> 30);
    end
    if (stage_en[6]) begin
      sc_r <= Q30_ONE - 31'(rcp_div(ps2_r, M_DIV20, K_DIV20));
      cc_r <= Q30_ONE - 31'(rcp_div(pc2_r, M_DIV12, K_DIV12));
    end
    if (stage_en[7]) begin
      ps3_r <= 30'(ps3_p >> 30);
      pc3_r <= 30'(pc3_p >> 30);
    end
    if (stage_en[8]) begin
      sd_r <= Q30_ONE - 31'(rcp_div(ps3_r, M_DIV6, K_DIV6));
      cd_r <= Q30_ONE - 31'(pc3_r >> 1);
    end
    if (stage_en[9]) begin
      sf_r <= 30'(sf_p >> 30);
      cf_r <= cd_r;
    end
    if (stage_en[10]) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

`default_nettype wire
